// ----- hw/rtl/oda_pkg.sv -----
// Package for the odometry delta accumulator: modes, quaternion component
// indexes, sequencer state, multiply-accumulate control word and product tables.
// No dependencies.
`default_nettype none

package oda_pkg;

    localparam logic [1:0] MODE_POSE  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [1:0] QX = 2'd0;
    localparam logic [1:0] QY = 2'd1;
    localparam logic [1:0] QZ = 2'd2;
    localparam logic [1:0] QW = 2'd3;

    localparam logic signed [31:0] QONE    = 32'sh4000_0000;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    localparam logic PASS_T   = 1'b0;
    localparam logic PASS_ACC = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_DONE
    } oda_state_t;

    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic neg;
    } oda_mac_ctl_t;

    // Hamilton product r = a * b, four terms per component, components x, y, z, w.
    localparam logic [1:0] SEL_A [16] = '{
        QW, QX, QY, QZ,  QW, QY, QZ, QX,  QW, QZ, QX, QY,  QW, QX, QY, QZ
    };
    localparam logic [1:0] SEL_B [16] = '{
        QX, QW, QZ, QY,  QY, QW, QX, QZ,  QZ, QW, QY, QX,  QW, QX, QY, QZ
    };
    localparam logic TERM_NEG [16] = '{
        1'b0, 1'b0, 1'b0, 1'b1,  1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,  1'b0, 1'b1, 1'b1, 1'b1
    };

    function automatic logic signed [31:0] oda_neg_sat(input logic signed [31:0] v);
        logic signed [31:0] r;
        if (v == SAT_MIN) begin
            r = SAT_MAX;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] oda_sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = SAT_MIN;
        end else begin
            r = SAT_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/oda_mac.sv -----
// Shared multiply-accumulate unit: one 32x32 product per cycle, a 66-bit
// accumulator and a round-to-nearest, saturating Q2.30 output stage.
// Depends on oda_pkg.
`default_nettype none

module oda_mac
    import oda_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire oda_mac_ctl_t        ctl,
    input  wire logic signed [31:0]  op_a,
    input  wire logic signed [31:0]  op_b,
    output logic                     res_vld,
    output logic signed [31:0]       res
);

    oda_mac_ctl_t       ctl1_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic               acc_last_reg;
    logic               res_vld_reg;
    logic signed [31:0] res_reg;

    logic signed [65:0] prod_ext;
    logic signed [65:0] acc_next;
    logic signed [65:0] rnd;
    logic signed [35:0] shr;
    logic signed [31:0] sat_next;

    always_comb begin
        prod_ext = {{2{prod_reg[63]}}, prod_reg};
        acc_next = (ctl1_reg.first ? 66'sd0 : acc_reg) +
                   (ctl1_reg.neg ? -prod_ext : prod_ext);
        rnd = acc_reg + 66'sd536870912;
        shr = rnd[65:30];
        if (shr[35:31] == 5'b00000 || shr[35:31] == 5'b11111) begin
            sat_next = shr[31:0];
        end else if (shr[35]) begin
            sat_next = SAT_MIN;
        end else begin
            sat_next = SAT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg     <= '0;
            acc_last_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end else begin
            ctl1_reg     <= ctl;
            acc_last_reg <= ctl1_reg.vld && ctl1_reg.last;
            res_vld_reg  <= acc_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (ctl1_reg.vld) begin
            acc_reg <= acc_next;
        end
        if (acc_last_reg) begin
            res_reg <= sat_next;
        end
    end

    assign res_vld = res_vld_reg;
    assign res     = res_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/odometry_delta_accumulator_core.sv -----
// Odometry delta accumulator top level: sequencer, pose and accumulator state,
// and the result register. Depends on oda_pkg and oda_mac.
//
// Channel   Direction  Ports                                   Word
// s_        in         s_valid, s_ready, s_mode, s_pos_*, ...  one pose, reset or read
// m_        out        m_valid, m_ready, m_delta_*, m_rot_*    accumulators and flag
//
// A pose after the first runs two quaternion products of 16 terms each through
// the single shared multiplier, each followed by a pipeline drain; the first
// pose runs one product, and reset and read words run none.
// The result register lets the next word be accepted while a result waits.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module odometry_delta_accumulator_core
    import oda_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_mode,
    input  wire logic signed [31:0]  s_pos_x,
    input  wire logic signed [31:0]  s_pos_y,
    input  wire logic signed [31:0]  s_pos_z,
    input  wire logic signed [31:0]  s_quat_x,
    input  wire logic signed [31:0]  s_quat_y,
    input  wire logic signed [31:0]  s_quat_z,
    input  wire logic signed [31:0]  s_quat_w,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_delta_x,
    output logic signed [31:0]       m_delta_y,
    output logic signed [31:0]       m_delta_z,
    output logic signed [31:0]       m_rot_x,
    output logic signed [31:0]       m_rot_y,
    output logic signed [31:0]       m_rot_z,
    output logic signed [31:0]       m_rot_w,
    output logic                     m_fresh
);

    oda_state_t         state_reg, state_next;
    logic [3:0]         idx_reg, idx_next;
    logic [1:0]         res_cnt_reg, res_cnt_next;
    logic               pass_reg;

    logic signed [31:0] prev_pos_reg [3];
    logic signed [31:0] prev_quat_reg [4];
    logic               have_prev_reg;
    logic signed [31:0] acc_pos_reg [3];
    logic signed [31:0] acc_rot_reg [4];
    logic               fresh_reg;

    logic signed [31:0] op_a_reg [4];
    logic signed [31:0] op_b_reg [4];
    logic signed [31:0] part_reg [4];

    logic               m_valid_reg;
    logic signed [31:0] m_pos_reg [3];
    logic signed [31:0] m_rot_reg [4];
    logic               m_fresh_reg;

    logic signed [31:0] pos_in [3];
    logic signed [31:0] quat_in [4];
    logic signed [31:0] pass_res [4];
    logic signed [33:0] pos_sum [3];
    logic               accept;
    logic               pass_end;
    logic               out_load;

    oda_mac_ctl_t       mac_ctl;
    logic signed [31:0] mac_a;
    logic signed [31:0] mac_b;
    logic               mac_res_vld;
    logic signed [31:0] mac_res;

    assign pos_in[0]      = s_pos_x;
    assign pos_in[1]      = s_pos_y;
    assign pos_in[2]      = s_pos_z;
    assign quat_in[QX]    = s_quat_x;
    assign quat_in[QY]    = s_quat_y;
    assign quat_in[QZ]    = s_quat_z;
    assign quat_in[QW]    = s_quat_w;

    assign accept   = s_valid && s_ready;
    assign pass_end = (state_reg == S_DRAIN) && mac_res_vld && (res_cnt_reg == 2'd3);
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pos_sum[i] = {{2{acc_pos_reg[i][31]}}, acc_pos_reg[i]} +
                         {{2{pos_in[i][31]}}, pos_in[i]} -
                         {{2{prev_pos_reg[i][31]}}, prev_pos_reg[i]};
        end
        pass_res[0] = part_reg[0];
        pass_res[1] = part_reg[1];
        pass_res[2] = part_reg[2];
        pass_res[3] = mac_res;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = (s_mode == MODE_POSE) ? S_ISSUE : S_DONE;
                end
            end
            S_ISSUE: begin
                if (idx_reg == 4'd15) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (pass_end) begin
                    state_next = (pass_reg == PASS_ACC) ? S_DONE : S_ISSUE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == S_IDLE);
        mac_ctl.vld   = (state_reg == S_ISSUE);
        mac_ctl.first = (idx_reg[1:0] == 2'd0);
        mac_ctl.last  = (idx_reg[1:0] == 2'd3);
        mac_ctl.neg   = TERM_NEG[idx_reg];
        mac_a         = op_a_reg[SEL_A[idx_reg]];
        mac_b         = op_b_reg[SEL_B[idx_reg]];
        idx_next      = (state_reg == S_ISSUE) ? idx_reg + 4'd1 : 4'd0;
        res_cnt_next  = mac_res_vld ? res_cnt_reg + 2'd1 : res_cnt_reg;
    end

    oda_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .res_vld (mac_res_vld),
        .res     (mac_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= 4'd0;
            res_cnt_reg   <= 2'd0;
            pass_reg      <= PASS_T;
            have_prev_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                prev_pos_reg[i] <= '0;
                acc_pos_reg[i]  <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                prev_quat_reg[i] <= '0;
            end
            acc_rot_reg[QX] <= '0;
            acc_rot_reg[QY] <= '0;
            acc_rot_reg[QZ] <= '0;
            acc_rot_reg[QW] <= QONE;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            res_cnt_reg <= res_cnt_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                case (s_mode)
                    MODE_POSE: begin
                        have_prev_reg <= 1'b1;
                        fresh_reg     <= 1'b1;
                        pass_reg      <= have_prev_reg ? PASS_T : PASS_ACC;
                        for (int i = 0; i < 3; i++) begin
                            prev_pos_reg[i] <= pos_in[i];
                            acc_pos_reg[i]  <= have_prev_reg ? oda_sat34(pos_sum[i])
                                                             : pos_in[i];
                        end
                        for (int i = 0; i < 4; i++) begin
                            prev_quat_reg[i] <= quat_in[i];
                        end
                    end
                    MODE_RESET: begin
                        for (int i = 0; i < 3; i++) begin
                            acc_pos_reg[i] <= '0;
                        end
                        acc_rot_reg[QX] <= '0;
                        acc_rot_reg[QY] <= '0;
                        acc_rot_reg[QZ] <= '0;
                        acc_rot_reg[QW] <= QONE;
                    end
                    MODE_READ: begin
                        fresh_reg <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (pass_end) begin
                if (pass_reg == PASS_T) begin
                    pass_reg <= PASS_ACC;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        acc_rot_reg[i] <= pass_res[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_mode == MODE_POSE) begin
            for (int i = 0; i < 4; i++) begin
                op_b_reg[i] <= quat_in[i];
            end
            if (have_prev_reg) begin
                op_a_reg[QX] <= oda_neg_sat(prev_quat_reg[QX]);
                op_a_reg[QY] <= oda_neg_sat(prev_quat_reg[QY]);
                op_a_reg[QZ] <= oda_neg_sat(prev_quat_reg[QZ]);
                op_a_reg[QW] <= prev_quat_reg[QW];
            end else begin
                for (int i = 0; i < 4; i++) begin
                    op_a_reg[i] <= acc_rot_reg[i];
                end
            end
        end else if (pass_end && pass_reg == PASS_T) begin
            for (int i = 0; i < 4; i++) begin
                op_a_reg[i] <= acc_rot_reg[i];
                op_b_reg[i] <= pass_res[i];
            end
        end
        if (mac_res_vld) begin
            part_reg[res_cnt_reg] <= mac_res;
        end
        if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                m_pos_reg[i] <= acc_pos_reg[i];
            end
            for (int i = 0; i < 4; i++) begin
                m_rot_reg[i] <= acc_rot_reg[i];
            end
            m_fresh_reg <= fresh_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_delta_x = m_pos_reg[0];
    assign m_delta_y = m_pos_reg[1];
    assign m_delta_z = m_pos_reg[2];
    assign m_rot_x   = m_rot_reg[QX];
    assign m_rot_y   = m_rot_reg[QY];
    assign m_rot_z   = m_rot_reg[QZ];
    assign m_rot_w   = m_rot_reg[QW];
    assign m_fresh   = m_fresh_reg;

`ifndef SYNTHESIS
    a_no_stray_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_res_vld |-> (state_reg == S_ISSUE || state_reg == S_DRAIN))
        else $error("Product result arrived outside a pose computation.");

    a_reset_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_RESET) |=>
            (acc_rot_reg[QW] == QONE && fresh_reg == $past(fresh_reg)))
        else $error("Reset word did not restore the identity rotation.");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid && state_reg == S_IDLE))
        else $error("Finished word was not presented on the result channel.");

    a_pose_sets_fresh: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_mode == MODE_POSE) |=> (fresh_reg && have_prev_reg))
        else $error("Pose word did not mark the accumulators as updated.");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for odometry_delta_accumulator_core: a predictor of the
// pose accumulators, a queue-fed driver and a checking monitor with random stalls.
// Depends on oda_pkg and the core RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oda_pkg::*;

    typedef logic [3:0][31:0] quat_t;
    typedef logic [2:0][31:0] vec3_t;
    typedef logic signed [71:0] wide_t;

    typedef struct packed {
        logic [1:0] mode;
        vec3_t      pos;
        quat_t      quat;
        logic [3:0] gap;
    } pose_word_t;

    typedef struct packed {
        vec3_t delta;
        quat_t rot;
        logic  fresh;
    } odom_out_t;

    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam wide_t W_MAX    = 72'sd2147483647;
    localparam wide_t W_MIN    = -72'sd2147483648;
    localparam wide_t HALF_LSB = 72'sd536870912;
    localparam int MAX_SHOWN   = 10;
    localparam int LONG_HOLD   = 300;
    localparam int RANDOM_WORDS = 1000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_valid  = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode   = MODE_READ;
    logic signed [31:0] s_pos_x  = '0;
    logic signed [31:0] s_pos_y  = '0;
    logic signed [31:0] s_pos_z  = '0;
    logic signed [31:0] s_quat_x = '0;
    logic signed [31:0] s_quat_y = '0;
    logic signed [31:0] s_quat_z = '0;
    logic signed [31:0] s_quat_w = '0;
    logic        m_valid;
    logic        m_ready  = 1'b0;
    logic signed [31:0] m_delta_x, m_delta_y, m_delta_z;
    logic signed [31:0] m_rot_x, m_rot_y, m_rot_z, m_rot_w;
    logic        m_fresh;

    pose_word_t pose_words[$];
    odom_out_t  due_results[$];
    int n_words    = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_bad      = 0;

    // Predicted block state.
    vec3_t prv_pos;
    quat_t prv_quat;
    logic  have_pose;
    vec3_t acc_pos;
    quat_t acc_rot;
    logic  fresh_flag;

    always #1 aclk = ~aclk;

    odometry_delta_accumulator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_mode   (s_mode),
        .s_pos_x  (s_pos_x),
        .s_pos_y  (s_pos_y),
        .s_pos_z  (s_pos_z),
        .s_quat_x (s_quat_x),
        .s_quat_y (s_quat_y),
        .s_quat_z (s_quat_z),
        .s_quat_w (s_quat_w),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_delta_x(m_delta_x),
        .m_delta_y(m_delta_y),
        .m_delta_z(m_delta_z),
        .m_rot_x  (m_rot_x),
        .m_rot_y  (m_rot_y),
        .m_rot_z  (m_rot_z),
        .m_rot_w  (m_rot_w),
        .m_fresh  (m_fresh)
    );

    function automatic wide_t widen(input logic [31:0] v);
        return {{40{v[31]}}, v};
    endfunction

    function automatic logic [31:0] clamp32(input wide_t v);
        logic [31:0] r;
        if (v > W_MAX) begin
            r = SAT_MAX;
        end else if (v < W_MIN) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic wide_t mul_q(input logic [31:0] a, input logic [31:0] b);
        return widen(a) * widen(b);
    endfunction

    // Q4.60 sum back to Q2.30, rounding half toward plus infinity.
    function automatic logic [31:0] round_q(input wide_t s);
        wide_t v;
        v = (s + HALF_LSB) >>> 30;
        return clamp32(v);
    endfunction

    function automatic quat_t hamilton(input quat_t a, input quat_t b);
        quat_t r;
        r[QX] = round_q(mul_q(a[QW], b[QX]) + mul_q(a[QX], b[QW])
                      + mul_q(a[QY], b[QZ]) - mul_q(a[QZ], b[QY]));
        r[QY] = round_q(mul_q(a[QW], b[QY]) + mul_q(a[QY], b[QW])
                      + mul_q(a[QZ], b[QX]) - mul_q(a[QX], b[QZ]));
        r[QZ] = round_q(mul_q(a[QW], b[QZ]) + mul_q(a[QZ], b[QW])
                      + mul_q(a[QX], b[QY]) - mul_q(a[QY], b[QX]));
        r[QW] = round_q(mul_q(a[QW], b[QW]) - mul_q(a[QX], b[QX])
                      - mul_q(a[QY], b[QY]) - mul_q(a[QZ], b[QZ]));
        return r;
    endfunction

    function automatic quat_t identity_quat();
        quat_t r;
        r = '0;
        r[QW] = QONE;
        return r;
    endfunction

    function automatic void clear_odometry();
        prv_pos    = '0;
        prv_quat   = '0;
        have_pose  = 1'b0;
        acc_pos    = '0;
        acc_rot    = identity_quat();
        fresh_flag = 1'b0;
    endfunction

    function automatic odom_out_t advance_odometry(input pose_word_t w);
        quat_t step_rot;
        quat_t conj;
        odom_out_t r;
        case (w.mode)
            MODE_POSE: begin
                if (have_pose) begin
                    for (int i = 0; i < 3; i++) begin
                        acc_pos[i] = clamp32(widen(acc_pos[i]) + widen(w.pos[i])
                                             - widen(prv_pos[i]));
                    end
                    conj[QX] = clamp32(-widen(prv_quat[QX]));
                    conj[QY] = clamp32(-widen(prv_quat[QY]));
                    conj[QZ] = clamp32(-widen(prv_quat[QZ]));
                    conj[QW] = prv_quat[QW];
                    step_rot = hamilton(conj, w.quat);
                end else begin
                    acc_pos  = w.pos;
                    step_rot = w.quat;
                end
                acc_rot    = hamilton(acc_rot, step_rot);
                prv_pos    = w.pos;
                prv_quat   = w.quat;
                have_pose  = 1'b1;
                fresh_flag = 1'b1;
            end
            MODE_RESET: begin
                acc_pos = '0;
                acc_rot = identity_quat();
            end
            MODE_READ: begin
                fresh_flag = 1'b0;
            end
            default: begin
            end
        endcase
        r.delta = acc_pos;
        r.rot   = acc_rot;
        r.fresh = fresh_flag;
        return r;
    endfunction

    function automatic void queue_word(input logic [1:0] mode,
                                       input logic [31:0] px, input logic [31:0] py,
                                       input logic [31:0] pz, input logic [31:0] qx,
                                       input logic [31:0] qy, input logic [31:0] qz,
                                       input logic [31:0] qw, input logic [3:0] gap);
        pose_word_t w;
        w.mode     = mode;
        w.pos[QX]  = px;
        w.pos[QY]  = py;
        w.pos[QZ]  = pz;
        w.quat[QX] = qx;
        w.quat[QY] = qy;
        w.quat[QZ] = qz;
        w.quat[QW] = qw;
        w.gap      = gap;
        pose_words.insert(pose_words.size(), w);
    endfunction

    function automatic logic [31:0] rand_span(input int unsigned half);
        return 32'($urandom_range(0, 2 * half)) - 32'(half);
    endfunction

    function automatic logic [31:0] rand_edge();
        logic [31:0] r;
        case ($urandom_range(0, 4))
            0: r = SAT_MAX;
            1: r = SAT_MIN;
            2: r = '0;
            3: r = QONE;
            default: r = -QONE;
        endcase
        return r;
    endfunction

    // Driver: presents queued words, waiting each word's gap before offering it.
    always @(posedge aclk) begin
        static pose_word_t cur;
        static pose_word_t nxt;
        static logic have_nxt = 1'b0;
        static int wait_cnt = 0;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.insert(due_results.size(), advance_odometry(cur));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (!have_nxt && pose_words.size() > 0) begin
                    nxt      = pose_words.pop_front();
                    have_nxt = 1'b1;
                    wait_cnt = nxt.gap;
                end
                if (have_nxt && wait_cnt == 0) begin
                    cur      = nxt;
                    have_nxt = 1'b0;
                    s_mode   <= cur.mode;
                    s_pos_x  <= cur.pos[QX];
                    s_pos_y  <= cur.pos[QY];
                    s_pos_z  <= cur.pos[QZ];
                    s_quat_x <= cur.quat[QX];
                    s_quat_y <= cur.quat[QY];
                    s_quat_z <= cur.quat[QZ];
                    s_quat_w <= cur.quat[QW];
                    s_valid  <= 1'b1;
                end else begin
                    if (have_nxt) begin
                        wait_cnt--;
                    end
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest prediction.
    always @(posedge aclk) begin
        static int hold_cnt = 0;
        odom_out_t got;
        odom_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got.delta[QX] = m_delta_x;
                got.delta[QY] = m_delta_y;
                got.delta[QZ] = m_delta_z;
                got.rot[QX]   = m_rot_x;
                got.rot[QY]   = m_rot_y;
                got.rot[QZ]   = m_rot_z;
                got.rot[QW]   = m_rot_w;
                got.fresh     = m_fresh;
                if (due_results.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN) begin
                        $display("mon: unexpected result word %h", got);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        n_bad++;
                        if (n_bad <= MAX_SHOWN) begin
                            $display("mon: mismatch on result %0d", n_checked);
                            $display("  delta exp %h %h %h got %h %h %h",
                                     want.delta[QX], want.delta[QY], want.delta[QZ],
                                     got.delta[QX], got.delta[QY], got.delta[QZ]);
                            $display("  rot exp %h %h %h %h got %h %h %h %h",
                                     want.rot[QX], want.rot[QY], want.rot[QZ],
                                     want.rot[QW], got.rot[QX], got.rot[QY],
                                     got.rot[QZ], got.rot[QW]);
                            $display("  fresh exp %b got %b", want.fresh, got.fresh);
                        end
                    end
                end
                n_checked++;
                if (n_checked == 400 || n_checked == 800) begin
                    hold_cnt = LONG_HOLD;
                end else if ((n_checked >= 150 && n_checked < 250) ||
                             (n_checked >= 650 && n_checked < 750)) begin
                    hold_cnt = 0;
                end else begin
                    hold_cnt = $urandom_range(0, 8);
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [31:0] walk [3];
        logic [31:0] pq [4];
        logic [3:0] gap;
        int pick;
        clear_odometry();

        queue_word(MODE_READ, '0, '0, '0, '0, '0, '0, '0, 4'd0);
        queue_word(MODE_NOP, SAT_MAX, SAT_MIN, '0, '0, '0, '0, '0, 4'd0);
        queue_word(MODE_POSE, SAT_MAX, SAT_MAX, SAT_MAX, '0, '0, '0, QONE, 4'd0);
        queue_word(MODE_POSE, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN,
                   SAT_MIN, 4'd0);
        queue_word(MODE_POSE, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                   SAT_MAX, 4'd3);
        queue_word(MODE_POSE, SAT_MIN, '0, SAT_MAX, SAT_MIN, SAT_MIN, SAT_MIN,
                   SAT_MAX, 4'd0);
        queue_word(MODE_READ, '1, '1, '1, '1, '1, '1, '1, 4'd1);
        queue_word(MODE_READ, '0, '0, '0, '0, '0, '0, '0, 4'd0);
        queue_word(MODE_RESET, '1, '1, '1, '1, '1, '1, '1, 4'd0);
        queue_word(MODE_POSE, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                   32'h0100_0000, '0, '0, 32'h3FFF_0000, 4'd2);
        queue_word(MODE_NOP, '1, '1, '1, '1, '1, '1, '1, 4'd0);
        queue_word(MODE_POSE, '0, '0, '0, '0, '0, '0, '0, 4'd0);
        queue_word(MODE_POSE, '0, '0, '0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 4'd0);
        queue_word(MODE_POSE, 32'h1234_5678, 32'h8765_4321, '0, '0, '0, '0, -QONE, 4'd5);
        queue_word(MODE_RESET, '0, '0, '0, '0, '0, '0, '0, 4'd0);
        queue_word(MODE_POSE, 32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000,
                   32'h0020_0000, 32'hFFE0_0000, 32'h0010_0000, 32'h3FFE_0000, 4'd0);
        queue_word(MODE_POSE, 32'h0002_8000, 32'h0003_4000, 32'hFFFE_2000,
                   32'hFFF0_0000, 32'h0008_0000, 32'h0030_0000, 32'h3FFD_0000, 4'd8);
        queue_word(MODE_READ, '0, '0, '0, '0, '0, '0, '0, 4'd0);

        for (int i = 0; i < 3; i++) begin
            walk[i] = $urandom;
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ((n >= 200 && n < 300) || (n >= 600 && n < 700)) begin
                gap = 4'd0;
            end else begin
                gap = 4'($urandom_range(0, 8));
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                for (int i = 0; i < 3; i++) begin
                    case ($urandom_range(0, 19))
                        0, 1: walk[i] = $urandom;
                        2: walk[i] = rand_edge();
                        default: walk[i] = walk[i] + rand_span(1 << 20);
                    endcase
                end
                case ($urandom_range(0, 9))
                    0, 1: begin
                        for (int i = 0; i < 4; i++) pq[i] = $urandom;
                    end
                    2: begin
                        for (int i = 0; i < 4; i++) pq[i] = rand_edge();
                    end
                    default: begin
                        for (int i = 0; i < 3; i++) pq[i] = rand_span(1 << 24);
                        pq[3] = QONE - 32'($urandom_range(0, 1 << 20));
                    end
                endcase
                queue_word(MODE_POSE, walk[0], walk[1], walk[2],
                           pq[0], pq[1], pq[2], pq[3], gap);
            end else if (pick < 82) begin
                queue_word(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, gap);
            end else if (pick < 90) begin
                queue_word(MODE_RESET, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, gap);
            end else if (pick < 93) begin
                queue_word(MODE_NOP, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, gap);
            end else begin
                queue_word(MODE_POSE, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, gap);
            end
        end
        n_words = pose_words.size();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (n_accepted != n_words || due_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        if (n_bad == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
